// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the receive FIFO modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mcrf_pkg.sv =====
// Package: field widths, operation and status codes, pointer command type.
`timescale 1ns / 1ps
`default_nettype none

package mcrf_pkg;

  // Field widths of the item and result ports
  localparam int OPCODE_W = 2;
  localparam int CHAN_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  // Default sizing
  localparam int CHANNELS_DEF = 6;
  localparam int DEPTH_DEF    = 64;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_FLUSH = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

  // Pointer table update for the selected channel (at most one set)
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ptr_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/mcrf_store.sv =====
// Shared byte store: single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module mcrf_store #(
  parameter int CHANNELS = mcrf_pkg::CHANNELS_DEF,
  parameter int DEPTH    = mcrf_pkg::DEPTH_DEF,
  localparam int ENTRIES = CHANNELS * DEPTH,
  localparam int ADDR_W  = $clog2(ENTRIES)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic                        re,
  input  wire logic [ADDR_W-1:0]           addr,
  input  wire logic [mcrf_pkg::BYTE_W-1:0] wdata,
  output logic      [mcrf_pkg::BYTE_W-1:0] rdata
);

  logic [mcrf_pkg::BYTE_W-1:0] mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mcrf_ptr.sv =====
// Per-channel pointer table: write index, read index and fill count.
`timescale 1ns / 1ps
`default_nettype none

module mcrf_ptr #(
  parameter int CHANNELS = mcrf_pkg::CHANNELS_DEF,
  parameter int DEPTH    = mcrf_pkg::DEPTH_DEF,
  localparam int IDX_W   = $clog2(DEPTH),
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CH_W-1:0]   ch_sel,
  input  wire mcrf_pkg::ptr_cmd_t cmd,
  output logic      [IDX_W-1:0]  sel_wr_idx,
  output logic      [IDX_W-1:0]  sel_rd_idx,
  output logic      [CNT_W-1:0]  sel_cnt
);

`include "assert_macros.svh"

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [IDX_W-1:0] wr_idx [CHANNELS];
  logic [IDX_W-1:0] rd_idx [CHANNELS];
  logic [CNT_W-1:0] cnt    [CHANNELS];

  // ring index step with wrap at the depth
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
    advance = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
  endfunction

  // lookup for the addressed channel
  assign sel_wr_idx = wr_idx[ch_sel];
  assign sel_rd_idx = rd_idx[ch_sel];
  assign sel_cnt    = cnt[ch_sel];

  // update of the addressed channel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wr_idx[i] <= '0;
        rd_idx[i] <= '0;
        cnt[i]    <= '0;
      end
    end else if (cmd.flush) begin
      wr_idx[ch_sel] <= '0;
      rd_idx[ch_sel] <= '0;
      cnt[ch_sel]    <= '0;
    end else if (cmd.push) begin
      wr_idx[ch_sel] <= advance(sel_wr_idx);
      cnt[ch_sel]    <= sel_cnt + CNT_W'(1);
    end else if (cmd.pop) begin
      rd_idx[ch_sel] <= advance(sel_rd_idx);
      cnt[ch_sel]    <= sel_cnt - CNT_W'(1);
    end
  end

  `ASSERT_IMPLY(a_pop_not_empty, cmd.pop, sel_cnt != '0, "pop issued on an empty ring")
  `ASSERT_IMPLY(a_push_not_full, cmd.push, sel_cnt != CNT_FULL, "push issued on a full ring")

endmodule

`default_nettype wire

// ===== rtl/core/multi_channel_rx_fifo.sv =====
// Top level: item handshake, operation sequencer and result register.
//
// Multi-channel receive FIFO: CHANNELS byte rings of DEPTH entries share one
// single-port byte RAM; per-channel pointers and fill counts sit in a small
// register table. One item is handled at a time: a push, query, flush or
// failed pop goes from the item registers through the execute state to the
// result register; a successful pop also passes the read state, as the RAM
// read is registered. A new item is taken as soon as the previous one is in
// the result register, even if that result has not yet been collected; a
// result waiting at the output holds the next item in the execute cycle. No
// clearing pass is needed after reset: only bytes written by a push are ever read.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_rx_fifo #(
  parameter int CHANNELS = mcrf_pkg::CHANNELS_DEF,
  parameter int DEPTH    = mcrf_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mcrf_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [mcrf_pkg::CHAN_W-1:0]   channel,
  input  wire logic [mcrf_pkg::BYTE_W-1:0]   data_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [mcrf_pkg::BYTE_W-1:0]   data_out,
  output logic      [mcrf_pkg::STATUS_W-1:0] status,
  output logic                               is_empty
);

`include "assert_macros.svh"

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = $clog2(CHANNELS * DEPTH);

  localparam logic [mcrf_pkg::CHAN_W:0] CH_LIMIT = (mcrf_pkg::CHAN_W + 1)'(CHANNELS);
  localparam logic [CNT_W-1:0]          CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]          CNT_ONE  = CNT_W'(1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // captured item
  logic [mcrf_pkg::OPCODE_W-1:0] op_q;
  logic [mcrf_pkg::CHAN_W-1:0]   ch_q;
  logic [mcrf_pkg::BYTE_W-1:0]   byte_q;
  logic                          pop_last;

  logic [CH_W-1:0]   ch_sel;
  logic [IDX_W-1:0]  sel_wr_idx;
  logic [IDX_W-1:0]  sel_rd_idx;
  logic [CNT_W-1:0]  sel_cnt;
  logic              ch_bad;
  logic              sel_full;
  logic              sel_empty;
  logic              out_free;
  logic              exec_go;
  mcrf_pkg::ptr_cmd_t cmd;

  logic [ADDR_W-1:0]             mem_base;
  logic [ADDR_W-1:0]             mem_addr;
  logic [mcrf_pkg::BYTE_W-1:0]   mem_rdata;

  logic [mcrf_pkg::STATUS_W-1:0] res_status;
  logic                          res_empty;

  assign in_ready = (state == S_IDLE);

  // item capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= opcode;
      ch_q   <= channel;
      byte_q <= data_in;
    end
  end

  // decode against the addressed channel's pointers
  assign ch_bad    = ({1'b0, ch_q} >= CH_LIMIT);
  assign ch_sel    = ch_q[CH_W-1:0];
  assign sel_full  = (sel_cnt == CNT_FULL);
  assign sel_empty = (sel_cnt == '0);
  assign out_free  = !out_valid || out_ready;
  assign exec_go   = (state == S_EXEC) && out_free;

  assign cmd.push  = exec_go && !ch_bad && (op_q == mcrf_pkg::OP_PUSH) && !sel_full;
  assign cmd.pop   = exec_go && !ch_bad && (op_q == mcrf_pkg::OP_POP) && !sel_empty;
  assign cmd.flush = exec_go && !ch_bad && (op_q == mcrf_pkg::OP_FLUSH);

  // byte address: channel base plus ring slot
  assign mem_base = ADDR_W'(ch_sel) * ADDR_W'(DEPTH);
  assign mem_addr = mem_base + ADDR_W'(cmd.pop ? sel_rd_idx : sel_wr_idx);

  // result for everything but a successful pop
  always_comb begin
    res_status = mcrf_pkg::ST_OK;
    res_empty  = sel_empty;
    if (ch_bad) begin
      res_status = mcrf_pkg::ST_BAD_CH;
      res_empty  = 1'b1;
    end else begin
      case (op_q)
        mcrf_pkg::OP_PUSH: begin
          if (sel_full) begin
            res_status = mcrf_pkg::ST_DROPPED;
          end
          res_empty = 1'b0;
        end
        mcrf_pkg::OP_POP: begin
          if (sel_empty) begin
            res_status = mcrf_pkg::ST_EMPTY;
          end
        end
        mcrf_pkg::OP_FLUSH: res_empty = 1'b1;
        default: res_empty = sel_empty;
      endcase
    end
  end

  mcrf_ptr #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH)
  ) u_ptr (
    .clk        (clk),
    .rst        (rst),
    .ch_sel     (ch_sel),
    .cmd        (cmd),
    .sel_wr_idx (sel_wr_idx),
    .sel_rd_idx (sel_rd_idx),
    .sel_cnt    (sel_cnt)
  );

  mcrf_store #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.push),
    .re    (cmd.pop),
    .addr  (mem_addr),
    .wdata (byte_q),
    .rdata (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = cmd.pop ? S_READ : S_IDLE;
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring drains with this pop
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      pop_last <= (sel_cnt == CNT_ONE);
    end
  end

  // result register: valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((exec_go && !cmd.pop) || (state == S_READ)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk) begin
    if (exec_go && !cmd.pop) begin
      data_out <= '0;
      status   <= res_status;
      is_empty <= res_empty;
    end else if (state == S_READ) begin
      data_out <= mem_rdata;
      status   <= mcrf_pkg::ST_OK;
      is_empty <= pop_last;
    end
  end

  `ASSERT_IMPLY(a_read_slot_free, state == S_READ, !out_valid, "RAM data arrives with result held")
  `ASSERT_NEXT(a_pop_then_read, cmd.pop, state == S_READ, "pop read not followed by capture")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the multi-channel receive byte FIFO.
`timescale 1ns / 1ps

module tb_top;
  import mcrf_pkg::*;

  localparam int CHANNELS    = 6;
  localparam int DEPTH       = 64;
  localparam int ITEMS       = 950;
  localparam int PH1_END     = 350;     // sender mostly busy, receiver mostly idle
  localparam int PH2_END     = 700;     // the other way round, then no idling
  localparam int DRAIN_AT    = 500;     // sender waits for every reply before this item
  localparam int STALL_AT    = 760;     // long receiver hold-off starts here
  localparam int STALL_LEN   = 240;
  localparam int TAIL_CYCLES = 10;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [CHAN_W-1:0]   ch;
    logic [BYTE_W-1:0]   dat;
    bit                  drain_first;
  } fifo_op_t;

  typedef struct {
    logic [BYTE_W-1:0]   dout;
    logic [STATUS_W-1:0] st;
    logic                empty;
  } fifo_reply_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [OPCODE_W-1:0] opcode    = OP_PUSH;
  logic [CHAN_W-1:0]   channel   = '0;
  logic [BYTE_W-1:0]   data_in   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   data_out;
  logic [STATUS_W-1:0] status;
  logic                is_empty;

  fifo_op_t    fifo_ops[$];
  fifo_reply_t expected_replies[$];

  int items_accepted = 0;
  int replies_seen   = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int stall_left     = 0;
  bit stall_done     = 1'b0;

  // Shadow copy of the rings
  logic [BYTE_W-1:0] ring_bytes [CHANNELS*DEPTH];
  int                ring_wr    [CHANNELS];
  int                ring_rd    [CHANNELS];
  int                ring_fill  [CHANNELS];

  multi_channel_rx_fifo #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .channel   (channel),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .status    (status),
    .is_empty  (is_empty)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow rings and return the reply it should give
  function automatic fifo_reply_t predict_fifo_op(logic [OPCODE_W-1:0] op,
                                                  logic [CHAN_W-1:0] ch,
                                                  logic [BYTE_W-1:0] dat);
    fifo_reply_t r;
    int c;
    c       = int'(ch);
    r.dout  = '0;
    r.st    = ST_OK;
    r.empty = 1'b1;
    if (c >= CHANNELS) begin
      r.st = ST_BAD_CH;
      return r;
    end
    case (op)
      OP_PUSH: begin
        if (ring_fill[c] < DEPTH) begin
          ring_bytes[c*DEPTH + ring_wr[c]] = dat;
          ring_wr[c]   = (ring_wr[c] == DEPTH-1) ? 0 : ring_wr[c] + 1;
          ring_fill[c] = ring_fill[c] + 1;
        end else begin
          r.st = ST_DROPPED;
        end
      end
      OP_POP: begin
        if (ring_fill[c] > 0) begin
          r.dout       = ring_bytes[c*DEPTH + ring_rd[c]];
          ring_rd[c]   = (ring_rd[c] == DEPTH-1) ? 0 : ring_rd[c] + 1;
          ring_fill[c] = ring_fill[c] - 1;
        end else begin
          r.st = ST_EMPTY;
        end
      end
      OP_QUERY: begin
      end
      default: begin
        ring_wr[c]   = 0;
        ring_rd[c]   = 0;
        ring_fill[c] = 0;
      end
    endcase
    r.empty = (ring_fill[c] == 0);
    return r;
  endfunction

  task automatic report_mismatch(string note);
    mismatches++;
    $display("MISMATCH reply %0d: %s", replies_seen, note);
  endtask

  task automatic add_op(logic [OPCODE_W-1:0] op, int ch, int dat);
    fifo_op_t it;
    it.op          = op;
    it.ch          = ch[CHAN_W-1:0];
    it.dat         = dat[BYTE_W-1:0];
    it.drain_first = (fifo_ops.size() == DRAIN_AT);
    fifo_ops.push_back(it);
  endtask

  // Driver: offers the next queued item, holds it until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_replies.push_back(predict_fifo_op(opcode, channel, data_in));
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (fifo_ops.size() != 0 &&
            !(fifo_ops[0].drain_first && expected_replies.size() != 0) &&
            $urandom_range(99) >= (items_accepted < PH1_END ? 9 :
                                   items_accepted < PH2_END ? 87 : 0)) begin
          in_valid <= 1'b1;
          opcode   <= fifo_ops[0].op;
          channel  <= fifo_ops[0].ch;
          data_in  <= fifo_ops[0].dat;
          void'(fifo_ops.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold-off to fill the block
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!stall_done && items_accepted >= STALL_AT) begin
      stall_done <= 1'b1;
      stall_left <= STALL_LEN;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= (items_accepted < PH1_END ? 87 :
                                           items_accepted < PH2_END ? 9 : 0));
    end
  end

  // Monitor: compare each reply taken with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply data %0h status %0d empty %0b",
                                  data_out, status, is_empty));
      end else begin
        if (data_out !== expected_replies[0].dout)
          report_mismatch($sformatf("data_out %0h, want %0h",
                                    data_out, expected_replies[0].dout));
        if (status !== expected_replies[0].st)
          report_mismatch($sformatf("status %0d, want %0d",
                                    status, expected_replies[0].st));
        if (is_empty !== expected_replies[0].empty)
          report_mismatch($sformatf("is_empty %0b, want %0b",
                                    is_empty, expected_replies[0].empty));
        void'(expected_replies.pop_front());
      end
      replies_seen <= replies_seen + 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: %0d replies still owed", expected_replies.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int  kind;
    int  ch;
    int  n;
    bit  first;

    for (int c = 0; c < CHANNELS; c++) begin
      ring_wr[c]   = 0;
      ring_rd[c]   = 0;
      ring_fill[c] = 0;
    end

    // Directed: empty ring, byte extremes, flush, bad channels
    add_op(OP_POP,   0, 8'h3C);
    add_op(OP_QUERY, 0, 8'h00);
    add_op(OP_FLUSH, 0, 8'hFF);
    add_op(OP_PUSH,  0, 8'h00);
    add_op(OP_PUSH,  0, 8'hFF);
    add_op(OP_QUERY, 0, 8'h00);
    add_op(OP_POP,   0, 8'h00);
    add_op(OP_POP,   0, 8'h00);
    add_op(OP_POP,   0, 8'h00);
    add_op(OP_PUSH,  5, 8'hA5);
    add_op(OP_PUSH,  5, 8'h5A);
    add_op(OP_FLUSH, 5, 8'h00);
    add_op(OP_POP,   5, 8'h00);
    add_op(OP_PUSH,  6, 8'hFF);
    add_op(OP_POP,   7, 8'h00);
    add_op(OP_QUERY, 6, 8'h00);
    add_op(OP_FLUSH, 7, 8'h00);
    add_op(OP_PUSH,  3, 8'h81);
    add_op(OP_PUSH,  4, 8'h7E);
    add_op(OP_POP,   3, 8'h00);
    add_op(OP_POP,   4, 8'h00);

    // Random sequences; the first one always overfills a ring
    first = 1'b1;
    while (fifo_ops.size() < ITEMS) begin
      kind  = first ? 36 : $urandom_range(99);
      first = 1'b0;
      ch    = $urandom_range(CHANNELS-1);
      if (kind < 35) begin
        n = $urandom_range(8, 1);
        repeat (n) add_op(OP_PUSH, ch, $urandom_range(255));
        n = $urandom_range(8, 0);
        repeat (n) add_op(OP_POP, ch, $urandom_range(255));
      end else if (kind < 40) begin
        // fill past full, then drain at least half of it so the read side can wrap
        n = $urandom_range(DEPTH+4, DEPTH+1);
        repeat (n) add_op(OP_PUSH, ch, $urandom_range(255));
        add_op(OP_QUERY, ch, $urandom_range(255));
        n = $urandom_range(DEPTH+2, DEPTH/2);
        repeat (n) add_op(OP_POP, ch, $urandom_range(255));
      end else if (kind < 58) begin
        n = $urandom_range(10, 1);
        repeat (n) add_op(OP_POP, ch, $urandom_range(255));
      end else if (kind < 72) begin
        add_op(OP_QUERY, ch, $urandom_range(255));
        add_op(OP_FLUSH, ch, $urandom_range(255));
        add_op(OP_QUERY, ch, $urandom_range(255));
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) add_op(OPCODE_W'($urandom_range(3)), $urandom_range(7),
                          $urandom_range(255));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (fifo_ops.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
